FILE: rtl/sacrr_pkg.sv
// ============================================================================
// sacrr_pkg
// Shared types, codes and the victim LFSR step for the set-associative cache.
// ============================================================================
`default_nettype none

package sacrr_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Way indices are carried at the width of the largest way count (16).
  localparam int unsigned WAY_ID_W = 4;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  typedef struct packed {
    logic                hit;
    logic [WAY_ID_W-1:0] found_way;
    logic [WAY_ID_W-1:0] target_way;
    logic                lfsr_step;
  } lookup_res_t;

  // Fibonacci x^16+x^14+x^13+x^11, shifting right, new bit in at the top.
  function automatic logic [15:0] lfsr_next(input logic [15:0] l);
    logic b;
    b = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {b, l[15:1]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sacrr_ram.sv
// ============================================================================
// sacrr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module sacrr_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sacrr_lookup.sv
// ============================================================================
// sacrr_lookup
// Tag compare across the ways of one set, and choice of the way to write.
// ============================================================================
`default_nettype none

module sacrr_lookup #(
  parameter int unsigned WAYS  = 4,
  parameter int unsigned TAG_W = 22
) (
  input  wire logic                        is_write,
  input  wire logic [TAG_W-1:0]            req_tag,
  input  wire logic [WAYS-1:0]             way_valid,
  input  wire logic [WAYS-1:0][TAG_W-1:0]  way_tag,
  input  wire logic [15:0]                 lfsr_q,
  output sacrr_pkg::lookup_res_t           res
);

  logic                           hit;
  logic [sacrr_pkg::WAY_ID_W-1:0] found;
  logic                           free_any;
  logic [sacrr_pkg::WAY_ID_W-1:0] free_way;
  logic [15:0]                    lfsr_adv;
  logic [sacrr_pkg::WAY_ID_W-1:0] victim;

  always_comb begin
    hit      = 1'b0;
    found    = '0;
    free_any = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (way_valid[w] && way_tag[w] == req_tag) begin
        hit   = 1'b1;
        found = sacrr_pkg::WAY_ID_W'(w);
      end
      if (!way_valid[w]) begin
        free_any = 1'b1;
        free_way = sacrr_pkg::WAY_ID_W'(w);
      end
    end
  end

  // way count is a power of two: the modulo is a mask
  assign lfsr_adv = sacrr_pkg::lfsr_next(lfsr_q);
  assign victim   = sacrr_pkg::WAY_ID_W'(lfsr_adv & 16'(WAYS - 1));

  always_comb begin
    res.hit       = hit;
    res.found_way = found;
    res.lfsr_step = is_write && !hit && !free_any;
    priority if (hit) begin
      res.target_way = found;
    end else if (free_any) begin
      res.target_way = free_way;
    end else begin
      res.target_way = victim;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/set_assoc_cache_random_replace.sv
// ============================================================================
// set_assoc_cache_random_replace
// Set-associative word cache, random (LFSR) replacement, no fill or write-back.
// Timing: the access is registered into the lookup stage at its transfer edge,
//   and the result into the output registers when that stage fires.
// Throughput: one access per cycle while out_ready is high; tags and words
//   read in a RAM cycle, then compare, select and write-back in one pass, with
//   one-deep write bypass. Reset: a clearing pass zeroes tag and data RAMs;
//   in_ready stays low until it ends.
// CACHE_BYTES, BLOCK_BYTES and WAYS are powers of two.
// ============================================================================
`default_nettype none

module set_assoc_cache_random_replace #(
  parameter int unsigned CACHE_BYTES = 4096,
  parameter int unsigned BLOCK_BYTES = 16,
  parameter int unsigned WAYS        = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_address,
  input  wire logic [31:0] in_write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic      [31:0] out_read_data
);

  localparam int unsigned SETS_RAW   = CACHE_BYTES / (BLOCK_BYTES * WAYS);
  localparam int unsigned SETS       = (SETS_RAW > 0) ? SETS_RAW : 1;
  localparam int unsigned OFF_W      = $clog2(BLOCK_BYTES);
  localparam int unsigned SET_W      = $clog2(SETS);
  localparam int unsigned SA_W       = (SET_W > 0) ? SET_W : 1;
  localparam int unsigned TAG_W      = 32 - OFF_W - SET_W;
  localparam int unsigned LINE_WORDS = BLOCK_BYTES / 4;
  localparam int unsigned DDEPTH     = SETS * LINE_WORDS;
  localparam int unsigned DA_W       = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;

  // clearing pass
  logic            clearing_r;
  logic [DA_W-1:0] clr_cnt_r;

  // lookup stage
  logic             s1_v_r;
  logic             s1_op_r;
  logic [SA_W-1:0]  s1_set_r;
  logic [DA_W-1:0]  s1_didx_r;
  logic [TAG_W-1:0] s1_tag_r;
  logic [31:0]      s1_wdata_r;

  // last write, for the RAM read that shares its edge
  logic                           bp_v_r;
  logic [sacrr_pkg::WAY_ID_W-1:0] bp_way_r;
  logic [SA_W-1:0]                bp_set_r;
  logic [DA_W-1:0]                bp_didx_r;
  logic [TAG_W-1:0]               bp_tag_r;
  logic [31:0]                    bp_data_r;

  logic [15:0] lfsr_r;

  logic        out_valid_r;
  logic        out_hit_r;
  logic [31:0] out_read_data_r;

  logic             in_fire;
  logic             s1_fire;
  logic             s1_wr;
  logic [SA_W-1:0]  in_set;
  logic [DA_W-1:0]  in_didx;
  logic [TAG_W-1:0] in_tag;

  logic [WAYS-1:0][TAG_W:0]   tag_q;
  logic [WAYS-1:0][31:0]      data_q;
  logic [WAYS-1:0]            way_valid;
  logic [WAYS-1:0][TAG_W-1:0] way_tag;
  logic [WAYS-1:0][31:0]      way_data;

  sacrr_pkg::lookup_res_t res;
  logic [31:0]            sel_data;

  assign in_set  = SA_W'(in_address >> OFF_W) & SA_W'(SETS - 1);
  assign in_didx = DA_W'(in_address >> 2) & DA_W'(DDEPTH - 1);
  assign in_tag  = TAG_W'(in_address >> (OFF_W + SET_W));

  assign s1_fire  = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !clearing_r && (!s1_v_r || s1_fire);
  assign in_fire  = in_valid && in_ready;
  assign s1_wr    = s1_fire && (s1_op_r == sacrr_pkg::OP_WRITE);

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic            way_we;
    logic            tag_bp;
    logic            data_bp;
    logic [SA_W-1:0] tag_waddr;
    logic [TAG_W:0]  tag_wdata;
    logic [DA_W-1:0] data_waddr;
    logic [31:0]     data_wdata;

    assign way_we = s1_wr && (res.target_way == sacrr_pkg::WAY_ID_W'(w));

    assign tag_waddr  = clearing_r ? (SA_W'(clr_cnt_r) & SA_W'(SETS - 1)) : s1_set_r;
    assign tag_wdata  = clearing_r ? '0 : {1'b1, s1_tag_r};
    assign data_waddr = clearing_r ? clr_cnt_r : s1_didx_r;
    assign data_wdata = clearing_r ? '0 : s1_wdata_r;

    sacrr_ram #(
      .WIDTH (TAG_W + 1),
      .DEPTH (SETS),
      .ADDR_W(SA_W)
    ) u_tag_ram (
      .clk  (clk),
      .we   (clearing_r || way_we),
      .waddr(tag_waddr),
      .wdata(tag_wdata),
      .re   (in_fire),
      .raddr(in_set),
      .rdata(tag_q[w])
    );

    sacrr_ram #(
      .WIDTH (32),
      .DEPTH (DDEPTH),
      .ADDR_W(DA_W)
    ) u_data_ram (
      .clk  (clk),
      .we   (clearing_r || way_we),
      .waddr(data_waddr),
      .wdata(data_wdata),
      .re   (in_fire),
      .raddr(in_didx),
      .rdata(data_q[w])
    );

    assign tag_bp  = bp_v_r && (bp_way_r == sacrr_pkg::WAY_ID_W'(w)) &&
                     (bp_set_r == s1_set_r);
    assign data_bp = bp_v_r && (bp_way_r == sacrr_pkg::WAY_ID_W'(w)) &&
                     (bp_didx_r == s1_didx_r);

    assign way_valid[w] = tag_bp ? 1'b1 : tag_q[w][TAG_W];
    assign way_tag[w]   = tag_bp ? bp_tag_r : tag_q[w][TAG_W-1:0];
    assign way_data[w]  = data_bp ? bp_data_r : data_q[w];
  end

  sacrr_lookup #(
    .WAYS (WAYS),
    .TAG_W(TAG_W)
  ) u_lookup (
    .is_write (s1_op_r == sacrr_pkg::OP_WRITE),
    .req_tag  (s1_tag_r),
    .way_valid(way_valid),
    .way_tag  (way_tag),
    .lfsr_q   (lfsr_r),
    .res      (res)
  );

  always_comb begin
    sel_data = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (res.found_way == sacrr_pkg::WAY_ID_W'(w)) begin
        sel_data = way_data[w];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == DA_W'(DDEPTH - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_operation;
      s1_set_r   <= in_set;
      s1_didx_r  <= in_didx;
      s1_tag_r   <= in_tag;
      s1_wdata_r <= in_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_v_r <= 1'b0;
      lfsr_r <= sacrr_pkg::LFSR_SEED;
    end else if (s1_wr) begin
      bp_v_r <= 1'b1;
      if (res.lfsr_step) begin
        lfsr_r <= sacrr_pkg::lfsr_next(lfsr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      bp_way_r  <= res.target_way;
      bp_set_r  <= s1_set_r;
      bp_didx_r <= s1_didx_r;
      bp_tag_r  <= s1_tag_r;
      bp_data_r <= s1_wdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_hit_r       <= res.hit;
      out_read_data_r <= (res.hit && s1_op_r == sacrr_pkg::OP_READ) ? sel_data : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_read_data = out_read_data_r;

  a_step_only_on_full_miss : assert property (
    @(posedge clk) disable iff (!rst_n)
    s1_v_r && res.lfsr_step |-> !res.hit && s1_op_r == sacrr_pkg::OP_WRITE
  ) else $error("victim LFSR stepped on a hit or a read");

  a_lfsr_holds : assert property (
    @(posedge clk) disable iff (!rst_n)
    !(s1_wr && res.lfsr_step) |=> lfsr_r == $past(lfsr_r)
  ) else $error("victim LFSR moved without a full-set write miss");

  a_miss_reads_zero : assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_read_data_r == '0
  ) else $error("miss returned non-zero data");

  a_no_transfer_while_clearing : assert property (
    @(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_v_r && !out_valid_r && !bp_v_r
  ) else $error("access in flight during the clearing pass");

endmodule

`default_nettype wire
